@@ rtl/u2u_pkg.sv @@
// ----------------------------------------------------------------------------
// u2u_pkg
// Shared word types and decoder state for the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u2u_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        run_last;
    logic        string_last;
  } out_word_t;

  typedef struct packed {
    logic [23:0] held_bytes;
    logic [1:0]  held_count;
    logic [2:0]  sequence_length;
  } dec_state_t;

  localparam int unsigned RunUnits = 3;

  typedef struct packed {
    logic [1:0]                 count;
    logic [RunUnits-1:0][15:0]  units;
    logic                       str_last;
  } run_t;

endpackage

@@ rtl/u2u_decode.sv @@
// ----------------------------------------------------------------------------
// u2u_decode
// Combinational decode of one byte against the pending sequence: next state
// and the run of zero to three UTF-16 units that the byte releases.
// ----------------------------------------------------------------------------
module u2u_decode
  import u2u_pkg::*;
(
  input  dec_state_t st,
  input  in_word_t   word,
  output dec_state_t st_nxt,
  output run_t       run
);

  localparam logic [15:0] REPL_UNIT = 16'hFFFD;
  localparam logic [20:0] SUPP_BASE = 21'h10000;
  localparam logic [15:0] HI_SURR   = 16'hD800;
  localparam logic [15:0] LO_SURR   = 16'hDC00;

  function automatic logic [2:0] lead_len(input logic [7:0] c);
    if (c[7] == 1'b0)              lead_len = 3'd1;
    else if ((c & 8'hE0) == 8'hC0) lead_len = 3'd2;
    else if ((c & 8'hF0) == 8'hE0) lead_len = 3'd3;
    else if ((c & 8'hF8) == 8'hF0) lead_len = 3'd4;
    else                           lead_len = 3'd0;
  endfunction

  function automatic logic [15:0] single_unit(input logic [7:0] c);
    single_unit = (c[7] == 1'b0) ? {8'h00, c} : REPL_UNIT;
  endfunction

  logic [7:0]  b;
  logic [7:0]  buf0, buf1, buf2, buf3;
  logic [2:0]  len;
  logic [2:0]  lb;
  logic [2:0]  l0;
  logic [2:0]  need;
  logic        hold;
  logic [20:0] cp;
  logic [20:0] sub;

  assign b    = word.in_byte;
  assign len  = {1'b0, st.held_count} + 3'd1;
  assign buf0 = (st.held_count == 2'd0) ? b : st.held_bytes[7:0];
  assign buf1 = (st.held_count == 2'd1) ? b : st.held_bytes[15:8];
  assign buf2 = (st.held_count == 2'd2) ? b : st.held_bytes[23:16];
  assign buf3 = b;
  assign lb   = lead_len(b);
  assign l0   = lead_len(buf0);
  assign need = (st.held_count != 2'd0) ? st.sequence_length :
                ((lb == 3'd0) ? 3'd1 : lb);
  assign hold = (len < need) && !word.last_byte;

  always_comb begin
    case (l0)
      3'd2:    cp = {10'd0, buf0[4:0], buf1[5:0]};
      3'd3:    cp = {5'd0, buf0[3:0], buf1[5:0], buf2[5:0]};
      3'd4:    cp = {buf0[2:0], buf1[5:0], buf2[5:0], buf3[5:0]};
      default: cp = {13'd0, buf0};
    endcase
  end

  assign sub = cp - SUPP_BASE;

  always_comb begin
    st_nxt       = '0;
    run          = '0;
    run.str_last = word.last_byte;
    if (hold) begin
      st_nxt.held_bytes      = st.held_bytes;
      case (st.held_count)
        2'd0:    st_nxt.held_bytes[7:0]   = b;
        2'd1:    st_nxt.held_bytes[15:8]  = b;
        default: st_nxt.held_bytes[23:16] = b;
      endcase
      st_nxt.held_count      = len[1:0];
      st_nxt.sequence_length = need;
    end else if (len >= need) begin
      if (l0 == 3'd0) begin
        run.count    = 2'd1;
        run.units[0] = REPL_UNIT;
      end else if (cp[20:16] != 5'd0) begin
        run.count    = 2'd2;
        run.units[0] = HI_SURR + {5'd0, sub[20:10]};
        run.units[1] = LO_SURR + {6'd0, sub[9:0]};
      end else begin
        run.count    = 2'd1;
        run.units[0] = cp[15:0];
      end
    end else begin
      // truncated at end of string: lead is replaced, tail decoded afresh
      run.units[0] = REPL_UNIT;
      case (len)
        3'd1: begin
          run.count = 2'd1;
        end
        3'd2: begin
          run.count    = 2'd2;
          run.units[1] = single_unit(buf1);
        end
        default: begin
          if (lead_len(buf1) == 3'd2) begin
            run.count    = 2'd2;
            run.units[1] = {5'd0, buf1[4:0], buf2[5:0]};
          end else begin
            run.count    = 2'd3;
            run.units[1] = single_unit(buf1);
            run.units[2] = single_unit(buf2);
          end
        end
      endcase
    end
  end

endmodule

@@ rtl/u2u_emit.sv @@
// ----------------------------------------------------------------------------
// u2u_emit
// Run register and serializer: holds one decoded run and sends its units one
// word per cycle on the result channel while out_ready is high.
// ----------------------------------------------------------------------------
module u2u_emit
  import u2u_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  run_t      run,
  output logic      take_ok,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  logic       busy_r, busy_nxt;
  run_t       run_r;
  logic [1:0] idx_r, idx_nxt;
  logic       fin;
  logic       shift;

  assign fin       = (idx_r == (run_r.count - 2'd1));
  assign shift     = busy_r && out_ready;
  assign take_ok   = !busy_r || (shift && fin);
  assign out_valid = busy_r;

  assign out_data.code_unit   = run_r.units[idx_r];
  assign out_data.run_last    = fin;
  assign out_data.string_last = fin && run_r.str_last;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = 2'd0;
    end else if (shift) begin
      if (fin) begin
        busy_nxt = 1'b0;
        idx_nxt  = 2'd0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      run_r <= run;
    end
  end

endmodule

@@ rtl/utf8_to_utf16_transcoder.sv @@
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// Lenient UTF-8 to UTF-16 transcoder, one byte word in, one code unit word out.
//
// Input channel in_valid/in_ready/in_data carries a byte and an end-of-string
// flag. Output channel out_valid/out_ready/out_data carries one UTF-16 code
// unit per word, with run_last on the final unit caused by a byte and
// string_last on the final unit of the string.
// An accepted byte is held in the input register and decoded from it; its run
// of units is loaded into the run register once the serializer can take it,
// and the first unit is offered from there. Throughput is one byte per cycle
// while the output keeps up; a byte releasing k units holds the input side
// until the serializer has sent them, one per cycle while out_ready is high.
// Bytes that only extend a pending sequence release nothing and pass at
// full rate even while the receiver stalls, until the input register backs
// up behind a run that is still waiting.
// Reset clears pending sequence state and drops any run not yet delivered.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder
  import u2u_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  logic       inv_r;
  in_word_t   in_r;
  dec_state_t st_r;
  dec_state_t st_nxt;
  run_t       run;
  logic       take_ok;
  logic       dec_fire;
  logic       load;

  u2u_decode u_decode (
    .st     (st_r),
    .word   (in_r),
    .st_nxt (st_nxt),
    .run    (run)
  );

  assign dec_fire = inv_r && ((run.count == 2'd0) || take_ok);
  assign load     = dec_fire && (run.count != 2'd0);
  assign in_ready = !inv_r || dec_fire;

  u2u_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .run       (run),
    .take_ok   (take_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= 1'b0;
      st_r  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        inv_r <= 1'b1;
      end else if (dec_fire) begin
        inv_r <= 1'b0;
      end
      if (dec_fire) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    dec_fire && in_r.last_byte |=> st_r.held_count == 2'd0)
    else $error("pending bytes survive end of string");

  a_need_exceeds_held: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.held_count != 2'd0 |-> st_r.sequence_length > {1'b0, st_r.held_count})
    else $error("held bytes already cover announced length");

  a_str_last_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.string_last |-> out_data.run_last)
    else $error("string_last on a unit that does not end its run");

  a_last_yields_run: assert property (@(posedge clk) disable iff (!rst_n)
    dec_fire && in_r.last_byte |-> load)
    else $error("end of string released no units");

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the UTF-8 to UTF-16 transcoder.
//
// Drives a short directed table of bytes (extremes, every lead class,
// surrogate pairs, overlong and out-of-range forms, truncation at the end of
// a string) followed by random strings built mostly from well-formed
// sequences with some noise bytes and cut-off sequences. Each accepted byte
// is run through a behavioral decoder in the bench, and every accepted code
// unit word is compared field by field with the oldest predicted unit. Both
// channels idle at random, and once the receiver holds off for a long
// stretch so that the block backs up and stalls its input.
// ----------------------------------------------------------------------------
module tb_top;
  import u2u_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int HoldCycles    = 200;
  localparam int RandomBytes   = 100;

  typedef struct {
    in_word_t    word;
    bit          typed;
    logic [15:0] unit;
  } plan_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;
  logic      rcv_ready = 1'b0;
  logic      hold_off = 1'b0;

  plan_row_t byte_plan[$];
  out_word_t pending_units[$];
  out_word_t run_units[3];
  int        dir_cnt;
  int        bytes_taken = 0;
  int        units_taken = 0;
  int        errors = 0;
  int        idle_cycles = 0;

  // decoder state of the bench
  logic [23:0] held_bytes = '0;
  logic [1:0]  held_cnt = '0;
  logic [2:0]  held_len = '0;

  assign out_ready = rcv_ready & ~hold_off;

  utf8_to_utf16_transcoder i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  function automatic int lead_len(logic [7:0] b);
    if (b < 8'h80) return 1;
    if ((b & 8'hE0) == 8'hC0) return 2;
    if ((b & 8'hF0) == 8'hE0) return 3;
    if ((b & 8'hF8) == 8'hF0) return 4;
    return 0;
  endfunction

  // Returns the number of units released by this byte, placed in run_units.
  function automatic int transcode_byte(in_word_t w);
    logic [7:0]  seq[4];
    logic [15:0] units[4];
    logic [20:0] cp;
    logic [20:0] cp_off;
    int          cnt;
    int          need;
    int          len;
    int          n;
    int          i;
    int          l;
    bit          bad;
    cnt = int'(held_cnt);
    for (i = 0; i < 4; i++) seq[i] = 8'h00;
    for (i = 0; i < cnt; i++) seq[i] = held_bytes[8*i +: 8];
    seq[cnt] = w.in_byte;
    len = cnt + 1;
    if (cnt == 0) begin
      need = lead_len(w.in_byte);
      if (need == 0) need = 1;
    end else begin
      need = int'(held_len);
    end
    if (len < need && !w.last_byte) begin
      held_bytes[8*cnt +: 8] = w.in_byte;
      held_cnt = len[1:0];
      held_len = need[2:0];
      return 0;
    end
    n = 0;
    i = 0;
    while (i < len) begin
      l = lead_len(seq[i]);
      bad = (l == 0) || (i + l > len);
      if (bad) begin
        cp = 21'hFFFD;
      end else begin
        case (l)
          1: cp = {13'd0, seq[i]};
          2: cp = {10'd0, seq[i][4:0], seq[i+1][5:0]};
          3: cp = {5'd0, seq[i][3:0], seq[i+1][5:0], seq[i+2][5:0]};
          default: cp = {seq[i][2:0], seq[i+1][5:0], seq[i+2][5:0], seq[i+3][5:0]};
        endcase
      end
      i += bad ? 1 : l;
      if (cp <= 21'h00FFFF) begin
        if (n < 4) begin
          units[n] = cp[15:0];
          n++;
        end
      end else begin
        cp_off = cp - 21'h010000;
        if (n < 4) begin
          units[n] = 16'hD800 + {5'd0, cp_off[20:10]};
          n++;
        end
        if (n < 4) begin
          units[n] = 16'hDC00 + {6'd0, cp_off[9:0]};
          n++;
        end
      end
    end
    if (n > 3) n = 3;
    for (i = 0; i < n; i++) begin
      run_units[i].code_unit   = units[i];
      run_units[i].run_last    = (i == n - 1);
      run_units[i].string_last = (i == n - 1) && w.last_byte;
    end
    held_bytes = '0;
    held_cnt = '0;
    held_len = '0;
    return n;
  endfunction

  task automatic add_byte(input logic [7:0] b, input bit l, input bit typed,
                          input logic [15:0] unit);
    plan_row_t r;
    r.word.in_byte   = b;
    r.word.last_byte = l;
    r.typed          = typed;
    r.unit           = unit;
    byte_plan = {byte_plan, r};
  endtask

  // byte side: predict on acceptance
  always @(posedge clk) begin
    int        n;
    out_word_t o;
    if (rst_n && in_valid && in_ready) begin
      n = transcode_byte(in_data);
      if (byte_plan[bytes_taken].typed) begin
        o.code_unit   = byte_plan[bytes_taken].unit;
        o.run_last    = 1'b1;
        o.string_last = in_data.last_byte;
        pending_units = {pending_units, o};
      end else begin
        for (int k = 0; k < n; k++) pending_units = {pending_units, run_units[k]};
      end
      bytes_taken++;
    end
  end

  // unit side: compare with oldest prediction
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      units_taken++;
      if (pending_units.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected word: unit=%h run_last=%b string_last=%b",
                   out_data.code_unit, out_data.run_last, out_data.string_last);
      end else begin
        exp_w = pending_units.pop_front();
        if (out_data !== exp_w) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp unit=%h rl=%b sl=%b  got unit=%h rl=%b sl=%b",
                     exp_w.code_unit, exp_w.run_last, exp_w.string_last,
                     out_data.code_unit, out_data.run_last, out_data.string_last);
        end
      end
    end
  end

  // watchdog: cycles with no word moving on either channel
  initial begin
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver
  initial begin
    int  gap;
    int  cnt;
    bit  quiet;
    cnt = 0;
    quiet = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (cnt % 25 == 0) quiet = ($urandom_range(0, 2) == 0);
      cnt++;
      gap = quiet ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        rcv_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rcv_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // long receiver stall while bytes keep coming
  initial begin
    @(posedge clk);
    while (!rst_n || bytes_taken < dir_cnt + 30) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    logic [7:0] str[$];
    logic [7:0] tmp;
    int         nchar;
    int         kind;
    int         nb;
    int         gap;
    bit         quiet;

    // after reset, extremes and invalid bytes
    add_byte(8'h41, 1'b1, 1'b1, 16'h0041);
    add_byte(8'h00, 1'b0, 1'b1, 16'h0000);
    add_byte(8'h7F, 1'b0, 1'b1, 16'h007F);
    add_byte(8'h80, 1'b0, 1'b1, 16'hFFFD);
    add_byte(8'hFF, 1'b1, 1'b1, 16'hFFFD);
    // two, three and four byte forms
    add_byte(8'hC3, 1'b0, 1'b0, 16'h0);
    add_byte(8'hA9, 1'b0, 1'b0, 16'h0);
    add_byte(8'hE2, 1'b0, 1'b0, 16'h0);
    add_byte(8'h82, 1'b0, 1'b0, 16'h0);
    add_byte(8'hAC, 1'b0, 1'b0, 16'h0);
    add_byte(8'hF0, 1'b0, 1'b0, 16'h0);
    add_byte(8'h9F, 1'b0, 1'b0, 16'h0);
    add_byte(8'h98, 1'b0, 1'b0, 16'h0);
    add_byte(8'h80, 1'b0, 1'b0, 16'h0);
    // above U+10FFFF, then overlong
    add_byte(8'hF7, 1'b0, 1'b0, 16'h0);
    add_byte(8'hBF, 1'b0, 1'b0, 16'h0);
    add_byte(8'hBF, 1'b0, 1'b0, 16'h0);
    add_byte(8'hBF, 1'b1, 1'b0, 16'h0);
    add_byte(8'hC0, 1'b0, 1'b0, 16'h0);
    add_byte(8'h80, 1'b0, 1'b0, 16'h0);
    // lead cut off by end of string, tails decoded again
    add_byte(8'hC3, 1'b1, 1'b1, 16'hFFFD);
    add_byte(8'hF0, 1'b0, 1'b0, 16'h0);
    add_byte(8'h41, 1'b0, 1'b0, 16'h0);
    add_byte(8'h42, 1'b1, 1'b0, 16'h0);
    add_byte(8'hF0, 1'b0, 1'b0, 16'h0);
    add_byte(8'hC3, 1'b0, 1'b0, 16'h0);
    add_byte(8'hA9, 1'b1, 1'b0, 16'h0);
    dir_cnt = byte_plan.size();

    while (byte_plan.size() < dir_cnt + RandomBytes) begin
      nchar = $urandom_range(1, 6);
      str.delete();
      for (int c = 0; c < nchar; c++) begin
        kind = $urandom_range(0, 9);
        case (kind)
          0, 1, 2: begin
            tmp = 8'($urandom_range(0, 127));
            str = {str, tmp};
          end
          3, 4: begin
            tmp = 8'hC0 | 8'($urandom_range(0, 31));
            str = {str, tmp};
            tmp = 8'h80 | 8'($urandom_range(0, 63));
            str = {str, tmp};
          end
          5, 6: begin
            tmp = 8'hE0 | 8'($urandom_range(0, 15));
            str = {str, tmp};
            repeat (2) begin
              tmp = 8'h80 | 8'($urandom_range(0, 63));
              str = {str, tmp};
            end
          end
          7: begin
            tmp = 8'hF0 | 8'($urandom_range(0, 7));
            str = {str, tmp};
            repeat (3) begin
              tmp = 8'h80 | 8'($urandom_range(0, 63));
              str = {str, tmp};
            end
          end
          8: begin
            tmp = 8'($urandom_range(0, 255));
            str = {str, tmp};
          end
          default: begin
            nb = $urandom_range(2, 4);
            if (nb == 2) tmp = 8'hC0 | 8'($urandom_range(0, 31));
            else if (nb == 3) tmp = 8'hE0 | 8'($urandom_range(0, 15));
            else tmp = 8'hF0 | 8'($urandom_range(0, 7));
            str = {str, tmp};
            repeat ($urandom_range(0, nb - 2)) begin
              tmp = 8'h80 | 8'($urandom_range(0, 63));
              str = {str, tmp};
            end
          end
        endcase
      end
      for (int k = 0; k < str.size(); k++)
        add_byte(str[k], k == str.size() - 1, 1'b0, 16'h0);
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    quiet = 1'b0;
    for (int i = 0; i < byte_plan.size(); i++) begin
      if (i % 25 == 0) quiet = ($urandom_range(0, 2) == 0);
      gap = quiet ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= byte_plan[i].word;
      do @(posedge clk); while (!in_ready);
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (pending_units.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_units.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
